// ----- rtl/rbpk_pkg.sv -----
`default_nettype none
package rbpk_pkg;
  localparam int COMP_WIDTH = 20;
  localparam int ROT_FRAC = COMP_WIDTH - 2;
  localparam int VEC_FRAC = COMP_WIDTH - 8;
  localparam int WORD_WIDTH = 3 * COMP_WIDTH;
  localparam int PROD_WIDTH = 2 * COMP_WIDTH;
  localparam int ACC_WIDTH = PROD_WIDTH + 4;
  localparam int CFG_IDX_WIDTH = 2;

  localparam logic [1:0] FUNC_DISP = 2'd0;
  localparam logic [1:0] FUNC_VEL = 2'd1;
  localparam logic [1:0] FUNC_ACC = 2'd2;
  localparam logic [1:0] FUNC_ALL = 2'd3;

  localparam logic [CFG_IDX_WIDTH-1:0] REG_ROT0 = 2'd0;
  localparam logic [CFG_IDX_WIDTH-1:0] REG_ROT1 = 2'd1;
  localparam logic [CFG_IDX_WIDTH-1:0] REG_ROT2 = 2'd2;
  localparam logic [CFG_IDX_WIDTH-1:0] REG_OFFSET = 2'd3;

  typedef logic signed [COMP_WIDTH-1:0] comp_t;
  typedef logic [WORD_WIDTH-1:0] word_t;

  typedef struct packed {
    logic [1:0] func;
    word_t ref_rot_row0;
    word_t ref_rot_row1;
    word_t ref_rot_row2;
    word_t ref_origin;
    word_t ref_ang_vel;
    word_t ref_ang_acc;
    word_t ref_lin_vel;
    word_t ref_lin_acc;
  } in_item_t;

  typedef struct packed {
    word_t pt_rot_row0;
    word_t pt_rot_row1;
    word_t pt_rot_row2;
    word_t pt_position;
    word_t pt_ang_vel;
    word_t pt_ang_acc;
    word_t pt_lin_vel;
    word_t pt_lin_acc;
    logic saturated;
  } out_item_t;

  // Commands from the sequencer to the multiply-accumulate unit.
  typedef struct packed {
    logic clear;
    logic mac;
    logic sub;
    logic rot_scale;
    comp_t a;
    comp_t b;
  } mac_cmd_t;

  typedef struct packed {
    comp_t value;
    logic sat;
  } mac_res_t;

  function automatic comp_t get_comp(word_t w, logic [1:0] i);
    comp_t r;
    r = comp_t'(w >> (COMP_WIDTH * int'(i)));
    return r;
  endfunction

  function automatic logic [COMP_WIDTH+1:0] sat_range(logic signed [COMP_WIDTH+1:0] v);
    logic signed [COMP_WIDTH+1:0] hi;
    logic signed [COMP_WIDTH+1:0] lo;
    hi = (COMP_WIDTH+2)'((1 <<< (COMP_WIDTH - 1)) - 1);
    lo = -(COMP_WIDTH+2)'(1 <<< (COMP_WIDTH - 1));
    if (v > hi) return hi;
    if (v < lo) return lo;
    return v;
  endfunction
endpackage
`default_nettype wire

// ----- rtl/rigid_body_point_kinematics.sv -----
`default_nettype none
// One item is worked through as a sequence of short dot products on a single 20x20
// multiplier: each output component takes three products for a matrix entry, or two
// products and a spare slot for a cross product, then a round step. The block is not
// ready from the input transfer until the result transfer.
module rigid_body_point_kinematics
  import rbpk_pkg::*;
(
  input wire logic clk,
  input wire logic rst,
  input wire logic in_valid,
  output logic in_ready,
  input wire in_item_t in_data,
  output logic out_valid,
  input wire logic out_ready,
  output out_item_t out_data,
  input wire logic cfg_we,
  input wire logic [CFG_IDX_WIDTH-1:0] cfg_index,
  input wire word_t cfg_data
);
  typedef enum logic [2:0] {S_IDLE, S_DISP, S_VEL, S_ACC, S_OUT} state_t;
  // Jobs: 0 rot, 1 offset, 2 omega x q, 3 alpha x q, 4 omega x q for accel, 5 omega x n.
  typedef enum logic [2:0] {J_ROT, J_OFF, J_VXQ, J_AXQ, J_WXQ, J_WXN} job_t;

  state_t state;
  job_t job;
  logic [1:0] func;
  logic [1:0] row, col, step;
  word_t rot [3];
  word_t lrot [3];
  word_t loffs, qoff, pos, angv, anga, linv, lina;
  word_t r_rot0, r_rot1, r_rot2, r_orig, r_om, r_al, r_v, r_a;
  comp_t tmp [3];
  comp_t sum_t [3];
  logic sat;
  mac_cmd_t cmd;
  mac_res_t res;
  logic last_col;

  rbpk_mac u_mac (.clk(clk), .cmd(cmd), .res(res));

  assign in_ready = (state == S_IDLE);
  assign out_valid = (state == S_OUT);
  assign out_data = '{rot[0], rot[1], rot[2], pos, angv, anga, linv, lina, sat};
  assign last_col = (col == 2'd2);

  function automatic word_t rrow(logic [1:0] i, word_t a, word_t b, word_t c);
    case (i)
      2'd0: return a;
      2'd1: return b;
      default: return c;
    endcase
  endfunction

  // Operand selection for product number step of component col.
  always_comb begin
    comp_t a, b;
    word_t x, y;
    logic [1:0] i1, i2;
    logic neg;
    a = '0;
    b = '0;
    neg = 1'b0;
    x = '0;
    y = '0;
    i1 = (col == 2'd0) ? 2'd1 : (col == 2'd1) ? 2'd2 : 2'd0;
    i2 = (col == 2'd0) ? 2'd2 : (col == 2'd1) ? 2'd0 : 2'd1;
    case (job)
      J_ROT: begin
        a = get_comp(rrow(row, r_rot0, r_rot1, r_rot2), step);
        b = get_comp(lrot[step], col);
      end
      J_OFF: begin
        a = get_comp(rrow(col, r_rot0, r_rot1, r_rot2), step);
        b = get_comp(loffs, step);
      end
      default: begin
        case (job)
          J_VXQ, J_WXQ: begin x = r_om; y = qoff; end
          J_AXQ: begin x = r_al; y = qoff; end
          default: begin x = r_om; y = {tmp[2], tmp[1], tmp[0]}; end
        endcase
        if (step == 2'd0) begin
          a = get_comp(x, i1);
          b = get_comp(y, i2);
        end else begin
          a = get_comp(x, i2);
          b = get_comp(y, i1);
          neg = 1'b1;
        end
      end
    endcase
    cmd.clear = (step == 2'd3) || (state == S_IDLE);
    cmd.mac = (state != S_IDLE) && (state != S_OUT) && (step != 2'd3)
              && !(step == 2'd2 && job != J_ROT && job != J_OFF);
    cmd.sub = neg;
    cmd.rot_scale = (job == J_ROT) || (job == J_OFF);
    cmd.a = a;
    cmd.b = b;
  end

  always_ff @(posedge clk) begin
    logic signed [COMP_WIDTH+1:0] s;
    comp_t cv;
    logic hit;
    if (cfg_we && !rst) begin
      case (cfg_index)
        REG_ROT0: lrot[0] <= cfg_data;
        REG_ROT1: lrot[1] <= cfg_data;
        REG_ROT2: lrot[2] <= cfg_data;
        default: loffs <= cfg_data;
      endcase
    end
    if (rst) begin
      state <= S_IDLE;
      lrot[0] <= word_t'(1 << ROT_FRAC);
      lrot[1] <= word_t'(1 << ROT_FRAC) << COMP_WIDTH;
      lrot[2] <= word_t'(1 << ROT_FRAC) << (2 * COMP_WIDTH);
      loffs <= '0;
      rot[0] <= word_t'(1 << ROT_FRAC);
      rot[1] <= word_t'(1 << ROT_FRAC) << COMP_WIDTH;
      rot[2] <= word_t'(1 << ROT_FRAC) << (2 * COMP_WIDTH);
      qoff <= '0;
      pos <= '0;
      angv <= '0;
      anga <= '0;
      linv <= '0;
      lina <= '0;
      sat <= 1'b0;
      job <= J_ROT;
      row <= '0;
      col <= '0;
      step <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            func <= in_data.func;
            r_rot0 <= in_data.ref_rot_row0;
            r_rot1 <= in_data.ref_rot_row1;
            r_rot2 <= in_data.ref_rot_row2;
            r_orig <= in_data.ref_origin;
            r_om <= in_data.ref_ang_vel;
            r_al <= in_data.ref_ang_acc;
            r_v <= in_data.ref_lin_vel;
            r_a <= in_data.ref_lin_acc;
            sat <= 1'b0;
            row <= '0;
            col <= '0;
            step <= '0;
            case (in_data.func)
              FUNC_VEL: begin state <= S_VEL; job <= J_VXQ; end
              FUNC_ACC: begin state <= S_ACC; job <= J_AXQ; end
              default: begin state <= S_DISP; job <= J_ROT; end
            endcase
          end
        end
        S_OUT: begin
          if (out_ready) state <= S_IDLE;
        end
        default: begin
          if (step == 2'd2 && job != J_ROT && job != J_OFF) begin
            step <= 2'd3;
          end else if (step != 2'd3) begin
            step <= step + 2'd1;
          end else begin
            step <= '0;
            cv = res.value;
            hit = res.sat;
            case (job)
              J_ROT: rot[row][COMP_WIDTH*col +: COMP_WIDTH] <= cv;
              J_OFF: begin
                qoff[COMP_WIDTH*col +: COMP_WIDTH] <= cv;
                s = (COMP_WIDTH+2)'(get_comp(r_orig, col)) + (COMP_WIDTH+2)'(cv);
                hit = hit | (sat_range(s) != s);
                pos[COMP_WIDTH*col +: COMP_WIDTH] <= comp_t'(sat_range(s));
              end
              J_VXQ: begin
                s = (COMP_WIDTH+2)'(get_comp(r_v, col)) + (COMP_WIDTH+2)'(cv);
                hit = hit | (sat_range(s) != s);
                linv[COMP_WIDTH*col +: COMP_WIDTH] <= comp_t'(sat_range(s));
              end
              J_AXQ: sum_t[col] <= cv;
              J_WXQ: tmp[col] <= cv;
              default: begin
                s = (COMP_WIDTH+2)'(get_comp(r_a, col)) + (COMP_WIDTH+2)'(sum_t[col])
                    + (COMP_WIDTH+2)'(cv);
                hit = hit | (sat_range(s) != s);
                lina[COMP_WIDTH*col +: COMP_WIDTH] <= comp_t'(sat_range(s));
              end
            endcase
            sat <= sat | hit;
            if (!last_col) begin
              col <= col + 2'd1;
            end else begin
              col <= '0;
              case (job)
                J_ROT: begin
                  if (row == 2'd2) begin row <= '0; job <= J_OFF; end
                  else row <= row + 2'd1;
                end
                J_OFF: begin
                  if (func == FUNC_ALL) begin state <= S_VEL; job <= J_VXQ; end
                  else state <= S_OUT;
                end
                J_VXQ: begin
                  angv <= r_om;
                  if (func == FUNC_ALL) begin state <= S_ACC; job <= J_AXQ; end
                  else state <= S_OUT;
                end
                J_AXQ: job <= J_WXQ;
                J_WXQ: job <= J_WXN;
                default: begin
                  anga <= r_al;
                  state <= S_OUT;
                end
              endcase
            end
          end
        end
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_ready_out: assert property (@(posedge clk) disable iff (rst) !(in_ready && out_valid))
    else $error("ready and result shown together");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed before transfer");
  a_start: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready && !out_valid)
    else $error("item not started");
`endif
endmodule
`default_nettype wire

// ----- rtl/rbpk_mac.sv -----
`default_nettype none
module rbpk_mac
  import rbpk_pkg::*;
(
  input wire logic clk,
  input wire mac_cmd_t cmd,
  output mac_res_t res
);
  logic signed [PROD_WIDTH-1:0] prod;
  logic signed [ACC_WIDTH-1:0] acc;
  logic signed [ACC_WIDTH-1:0] rnd;
  logic signed [ACC_WIDTH-1:0] shifted;
  logic signed [ACC_WIDTH-1:0] hi;
  logic signed [ACC_WIDTH-1:0] lo;

  assign prod = cmd.a * cmd.b;

  always_ff @(posedge clk) begin
    if (cmd.clear) begin
      acc <= '0;
    end else if (cmd.mac) begin
      acc <= cmd.sub ? acc - ACC_WIDTH'(prod) : acc + ACC_WIDTH'(prod);
    end
  end

  always_comb begin
    hi = ACC_WIDTH'((1 <<< (COMP_WIDTH - 1)) - 1);
    lo = -ACC_WIDTH'(1 <<< (COMP_WIDTH - 1));
    if (cmd.rot_scale) begin
      rnd = acc + ACC_WIDTH'(1 <<< (ROT_FRAC - 1));
      shifted = rnd >>> ROT_FRAC;
    end else begin
      rnd = acc + ACC_WIDTH'(1 <<< (VEC_FRAC - 1));
      shifted = rnd >>> VEC_FRAC;
    end
    if (shifted > hi) begin
      res.value = comp_t'(hi);
      res.sat = 1'b1;
    end else if (shifted < lo) begin
      res.value = comp_t'(lo);
      res.sat = 1'b1;
    end else begin
      res.value = comp_t'(shifted);
      res.sat = 1'b0;
    end
  end
endmodule
`default_nettype wire

// ----- tb/sv/tb.sv -----
module tb;
  import rbpk_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LIMIT_CYCLES = 1000000;
  localparam int RANDOM_ITEMS = 1430;

  typedef logic signed [63:0] wide_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_item_t out_data;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_WIDTH-1:0] cfg_index = '0;
  word_t cfg_data = '0;

  rigid_body_point_kinematics uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  word_t local_rot [3];
  word_t local_offset;
  word_t rotated_offset;
  out_item_t held;
  logic sat_flag;

  out_item_t pending_results[$];
  int error_count = 0;
  int cycle_count = 0;
  int send_idle_pct = 0;
  int stall_pct = 0;

  function automatic wide_t get_signed(word_t w, int i);
    logic [COMP_WIDTH-1:0] u;
    u = w[i*COMP_WIDTH +: COMP_WIDTH];
    return wide_t'(signed'(u));
  endfunction

  function automatic wide_t clamp(wide_t v);
    wide_t hi;
    wide_t lo;
    hi = (64'sd1 <<< (COMP_WIDTH - 1)) - 1;
    lo = -(64'sd1 <<< (COMP_WIDTH - 1));
    if (v > hi) begin
      sat_flag = 1'b1;
      return hi;
    end
    if (v < lo) begin
      sat_flag = 1'b1;
      return lo;
    end
    return v;
  endfunction

  function automatic wide_t round_clamp(wide_t v, int s);
    v = v + (64'sd1 <<< (s - 1));
    return clamp(v >>> s);
  endfunction

  function automatic word_t pack3(wide_t x, wide_t y, wide_t z);
    word_t w;
    w[COMP_WIDTH-1:0] = x[COMP_WIDTH-1:0];
    w[2*COMP_WIDTH-1:COMP_WIDTH] = y[COMP_WIDTH-1:0];
    w[3*COMP_WIDTH-1:2*COMP_WIDTH] = z[COMP_WIDTH-1:0];
    return w;
  endfunction

  function automatic word_t cross_round(word_t a, word_t b);
    wide_t ax, ay, az, bx, by, bz;
    ax = get_signed(a, 0);
    ay = get_signed(a, 1);
    az = get_signed(a, 2);
    bx = get_signed(b, 0);
    by = get_signed(b, 1);
    bz = get_signed(b, 2);
    return pack3(round_clamp(ay * bz - az * by, VEC_FRAC),
                 round_clamp(az * bx - ax * bz, VEC_FRAC),
                 round_clamp(ax * by - ay * bx, VEC_FRAC));
  endfunction

  function automatic word_t add_vecs(word_t a, word_t b, word_t c);
    wide_t r [3];
    for (int i = 0; i < 3; i++)
      r[i] = clamp(get_signed(a, i) + get_signed(b, i) + get_signed(c, i));
    return pack3(r[0], r[1], r[2]);
  endfunction

  function automatic out_item_t kinematics_step(in_item_t it);
    word_t ref_rows [3];
    wide_t comps [3];
    wide_t acc;
    ref_rows[0] = it.ref_rot_row0;
    ref_rows[1] = it.ref_rot_row1;
    ref_rows[2] = it.ref_rot_row2;
    sat_flag = 1'b0;
    if (it.func == FUNC_DISP || it.func == FUNC_ALL) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          acc = 0;
          for (int k = 0; k < 3; k++)
            acc += get_signed(ref_rows[i], k) * get_signed(local_rot[k], j);
          comps[j] = round_clamp(acc, ROT_FRAC);
        end
        if (i == 0) held.pt_rot_row0 = pack3(comps[0], comps[1], comps[2]);
        else if (i == 1) held.pt_rot_row1 = pack3(comps[0], comps[1], comps[2]);
        else held.pt_rot_row2 = pack3(comps[0], comps[1], comps[2]);
      end
      for (int i = 0; i < 3; i++) begin
        acc = 0;
        for (int k = 0; k < 3; k++)
          acc += get_signed(ref_rows[i], k) * get_signed(local_offset, k);
        comps[i] = round_clamp(acc, ROT_FRAC);
      end
      rotated_offset = pack3(comps[0], comps[1], comps[2]);
      held.pt_position = add_vecs(it.ref_origin, rotated_offset, '0);
    end
    if (it.func == FUNC_VEL || it.func == FUNC_ALL) begin
      held.pt_ang_vel = it.ref_ang_vel;
      held.pt_lin_vel = add_vecs(it.ref_lin_vel, cross_round(it.ref_ang_vel, rotated_offset), '0);
    end
    if (it.func == FUNC_ACC || it.func == FUNC_ALL) begin
      held.pt_ang_acc = it.ref_ang_acc;
      held.pt_lin_acc = add_vecs(it.ref_lin_acc,
                                 cross_round(it.ref_ang_acc, rotated_offset),
                                 cross_round(it.ref_ang_vel,
                                             cross_round(it.ref_ang_vel, rotated_offset)));
    end
    held.saturated = sat_flag;
    return held;
  endfunction

  function automatic word_t random_word();
    return word_t'({$urandom(), $urandom()});
  endfunction

  // Components near unity or small keep most rotations out of saturation.
  function automatic wide_t modest_comp(int bits);
    int m;
    m = 1 << bits;
    return wide_t'($urandom_range(2 * m)) - m;
  endfunction

  function automatic word_t modest_word(int bits);
    return pack3(modest_comp(bits), modest_comp(bits), modest_comp(bits));
  endfunction

  function automatic in_item_t random_item();
    in_item_t it;
    int style;
    style = $urandom_range(9);
    it.func = 2'($urandom_range(3));
    if (style < 3) begin
      it.ref_rot_row0 = random_word();
      it.ref_rot_row1 = random_word();
      it.ref_rot_row2 = random_word();
      it.ref_origin = random_word();
      it.ref_ang_vel = random_word();
      it.ref_ang_acc = random_word();
      it.ref_lin_vel = random_word();
      it.ref_lin_acc = random_word();
    end else begin
      it.ref_rot_row0 = modest_word(ROT_FRAC);
      it.ref_rot_row1 = modest_word(ROT_FRAC);
      it.ref_rot_row2 = modest_word(ROT_FRAC);
      it.ref_origin = modest_word(VEC_FRAC + 4);
      it.ref_ang_vel = modest_word(VEC_FRAC + 1);
      it.ref_ang_acc = modest_word(VEC_FRAC + 2);
      it.ref_lin_vel = modest_word(VEC_FRAC + 4);
      it.ref_lin_acc = modest_word(VEC_FRAC + 4);
    end
    return it;
  endfunction

  task automatic write_reg(logic [CFG_IDX_WIDTH-1:0] idx, word_t value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_OFFSET) local_offset = value;
    else local_rot[idx] = value;
    @(posedge clk);
  endtask

  task automatic send_item(in_item_t it, out_item_t typed, logic use_typed);
    out_item_t predicted;
    if (($urandom_range(99)) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while (($urandom_range(99)) < send_idle_pct);
    end
    predicted = kinematics_step(it);
    if (use_typed && typed != predicted) begin
      error_count++;
      if (error_count <= 10)
        $display("predictor disagrees with table: table %h predicted %h", typed, predicted);
    end
    pending_results.push_back(use_typed ? typed : predicted);
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (120) @(posedge clk);
  endtask

  task automatic set_phase(int ph);
    case (ph % 4)
      0: begin send_idle_pct = 0; stall_pct = 0; end
      1: begin send_idle_pct = 56; stall_pct = 0; end
      2: begin send_idle_pct = 0; stall_pct = 56; end
      default: begin send_idle_pct = 26; stall_pct = 26; end
    endcase
  endtask

  always @(posedge clk) begin
    if (!rst) out_ready <= ($urandom_range(99)) >= stall_pct;
  end

  always @(posedge clk) begin
    out_item_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        error_count++;
        if (error_count <= 10) $display("unexpected result transfer: %h", out_data);
      end else begin
        want = pending_results.pop_front();
        if (out_data !== want) begin
          error_count++;
          if (error_count <= 10)
            $display("mismatch: expected %h actual %h", want, out_data);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  typedef struct {
    in_item_t stim;
    out_item_t typed;
    logic use_typed;
  } table_row_t;

  localparam word_t ID0 = word_t'(1) << ROT_FRAC;
  localparam word_t ID1 = word_t'(1) << (ROT_FRAC + COMP_WIDTH);
  localparam word_t ID2 = word_t'(1) << (ROT_FRAC + 2 * COMP_WIDTH);
  localparam word_t MAXW = pack3(64'sh7ffff, 64'sh7ffff, 64'sh7ffff);
  localparam word_t MINW = pack3(-64'sh80000, -64'sh80000, -64'sh80000);
  localparam word_t ONES = '1;

  table_row_t directed [$];

  function automatic table_row_t make_row(logic [1:0] f, word_t r0, word_t r1, word_t r2,
                                          word_t o, word_t w, word_t al, word_t v, word_t a);
    table_row_t row;
    row.stim = '{f, r0, r1, r2, o, w, al, v, a};
    row.typed = '0;
    row.use_typed = 1'b0;
    return row;
  endfunction

  initial begin
    table_row_t row;
    local_rot[0] = ID0;
    local_rot[1] = ID1;
    local_rot[2] = ID2;
    local_offset = '0;
    rotated_offset = '0;
    held = '0;
    held.pt_rot_row0 = ID0;
    held.pt_rot_row1 = ID1;
    held.pt_rot_row2 = ID2;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Identity everywhere with zero offset: displacement reproduces the frame.
    row = make_row(FUNC_DISP, ID0, ID1, ID2, 60'h123, '0, '0, '0, '0);
    row.typed = '{ID0, ID1, ID2, 60'h123, '0, '0, '0, '0, 1'b0};
    row.use_typed = 1'b1;
    directed.push_back(row);
    row = make_row(FUNC_VEL, '0, '0, '0, '0, MAXW, '0, 60'h5, '0);
    row.typed = '{ID0, ID1, ID2, 60'h123, MAXW, '0, 60'h5, '0, 1'b0};
    row.use_typed = 1'b1;
    directed.push_back(row);
    directed.push_back(make_row(FUNC_ACC, '0, '0, '0, '0, MINW, MAXW, '0, MINW));
    directed.push_back(make_row(FUNC_ALL, MAXW, MINW, MAXW, MAXW, MAXW, MINW, MAXW, MAXW));
    directed.push_back(make_row(FUNC_ALL, MINW, MINW, MINW, MINW, MINW, MINW, MINW, MINW));
    directed.push_back(make_row(FUNC_ALL, ONES, ONES, ONES, ONES, ONES, ONES, ONES, ONES));
    directed.push_back(make_row(FUNC_DISP, ID0, ID1, ID2, MAXW, '0, '0, '0, '0));
    directed.push_back(make_row(FUNC_VEL, ID0, ID1, ID2, '0, MAXW, '0, MAXW, '0));
    directed.push_back(make_row(FUNC_ACC, ID0, ID1, ID2, '0, MAXW, MAXW, '0, MAXW));

    set_phase(0);
    foreach (directed[i]) begin
      if (i == 3) begin
        wait_drained();
        write_reg(REG_OFFSET, MAXW);
      end
      if (i == 6) begin
        wait_drained();
        write_reg(REG_ROT0, MINW);
        write_reg(REG_ROT1, MAXW);
        write_reg(REG_ROT2, ONES);
        write_reg(REG_OFFSET, MINW);
      end
      send_item(directed[i].stim, directed[i].typed, directed[i].use_typed);
    end

    for (int ph = 0; ph < 8; ph++) begin
      wait_drained();
      set_phase(ph);
      case (ph)
        0, 4: begin
          write_reg(REG_ROT0, ID0);
          write_reg(REG_ROT1, ID1);
          write_reg(REG_ROT2, ID2);
          write_reg(REG_OFFSET, modest_word(VEC_FRAC + 3));
        end
        7: begin
          write_reg(REG_ROT0, random_word());
          write_reg(REG_ROT1, random_word());
          write_reg(REG_ROT2, random_word());
          write_reg(REG_OFFSET, ph[0] ? MINW : random_word());
        end
        default: begin
          write_reg(REG_ROT0, modest_word(ROT_FRAC));
          write_reg(REG_ROT1, modest_word(ROT_FRAC));
          write_reg(REG_ROT2, modest_word(ROT_FRAC));
          write_reg(REG_OFFSET, modest_word(VEC_FRAC + 4));
        end
      endcase
      for (int n = 0; n < RANDOM_ITEMS / 8; n++)
        send_item(random_item(), '0, 1'b0);
    end

    wait_drained();
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule
